// ----- hdl/vipsf_pkg.sv -----
// Package for the VLAN IP source filter: commands, reasons, counter codes,
// table depths and the shared status struct. No dependencies.
`timescale 1ns / 1ps
package vipsf_pkg;
  localparam int ALLOW4_DEPTH_DEF = 64;
  localparam int ALLOW6_DEPTH_DEF = 32;
  localparam int DENY4_DEPTH_DEF  = 64;
  localparam int DENY6_DEPTH_DEF  = 32;
  localparam int MAX_TAGS_DEF     = 2;

  localparam logic [2:0] CMD_BYTE   = 3'd0;
  localparam logic [2:0] CMD_ALLOW4 = 3'd1;
  localparam logic [2:0] CMD_ALLOW6 = 3'd2;
  localparam logic [2:0] CMD_DENY4  = 3'd3;
  localparam logic [2:0] CMD_DENY6  = 3'd4;
  localparam logic [2:0] CMD_CREAD  = 3'd5;

  localparam logic [2:0] RSN_TRUNC   = 3'd0;
  localparam logic [2:0] RSN_ALLOW   = 3'd1;
  localparam logic [2:0] RSN_DENY4   = 3'd2;
  localparam logic [2:0] RSN_DENY6   = 3'd3;
  localparam logic [2:0] RSN_DEFAULT = 3'd4;
  localparam logic [2:0] RSN_NONIP   = 3'd5;

  localparam int CNT_TOTAL  = 0;
  localparam int CNT_ALLOW  = 1;
  localparam int CNT_DENY4  = 2;
  localparam int CNT_DENY6  = 3;
  localparam int CNT_VLAN   = 4;
  localparam int CNT_V6SEEN = 5;
  localparam int CNT_NONIP  = 6;
  localparam int CNT_NUM    = 7;

  localparam logic [15:0] TPID_C   = 16'h8100;
  localparam logic [15:0] TPID_S   = 16'h88A8;
  localparam logic [15:0] ETYPE_V4 = 16'h0800;
  localparam logic [15:0] ETYPE_V6 = 16'h86DD;

  // Parser status handed to the sequencer at packet end.
  typedef struct packed {
    logic        long_enough;
    logic        tag_open;
    logic [1:0]  tags;
    logic        is_v4;
    logic        is_v6;
    logic        v4_full;
    logic        v6_full;
  } pkt_stat_t;

  function automatic logic [63:0] mask_hi(input logic [7:0] p);
    logic [63:0] m;
    m = '1;
    if (p == 8'd0) mask_hi = '0;
    else if (p >= 8'd64) mask_hi = m;
    else mask_hi = m << (7'd64 - {1'b0, p[5:0]});
  endfunction

  function automatic logic [63:0] mask_lo(input logic [7:0] p);
    logic [63:0] m;
    m = '1;
    if (p <= 8'd64) mask_lo = '0;
    else if (p >= 8'd128) mask_lo = m;
    else mask_lo = m << (8'd128 - p);
  endfunction
endpackage

// ----- hdl/vipsf_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module vipsf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule

// ----- hdl/vipsf_parser.sv -----
// Byte parser: VLAN stripping, ethertype tracking and source address capture.
// Depends on vipsf_pkg.
`timescale 1ns / 1ps
module vipsf_parser
  import vipsf_pkg::*;
#(
  parameter int MAX_TAGS = MAX_TAGS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        byte_i,
  input  logic        clear_i,
  input  logic [7:0]  data_i,
  output pkt_stat_t   stat_o,
  output logic [63:0] src_hi_o,
  output logic [63:0] src_lo_o
);
  logic [6:0]  off_q, off_d;
  logic [15:0] et_q, et_d;
  logic [1:0]  tags_q, tags_d;
  logic        open_q, open_d;
  logic [63:0] hi_q, hi_d, lo_q, lo_d;
  logic [6:0]  base, rel, len;
  logic [15:0] et_sh;
  logic        tp_ok;

  assign base  = 7'd14 + {3'd0, tags_q, 2'b00};
  assign rel   = off_q - base;
  assign et_sh = {et_q[7:0], data_i};
  assign tp_ok = (et_sh == TPID_C || et_sh == TPID_S);

  always_comb begin
    off_d = off_q; et_d = et_q; tags_d = tags_q; open_d = open_q;
    hi_d = hi_q; lo_d = lo_q;
    if (clear_i) begin
      off_d = '0; et_d = '0; tags_d = '0; open_d = 1'b0; hi_d = '0; lo_d = '0;
    end else if (byte_i) begin
      if (off_q == 7'd12 || off_q == 7'd13) begin
        et_d = et_sh;
        if (off_q == 7'd13) open_d = tp_ok && ({30'd0, tags_q} < MAX_TAGS);
      end else if (off_q >= 7'd14 && open_q) begin
        if (rel == 7'd2 || rel == 7'd3) et_d = et_sh;
        if (rel == 7'd3) begin
          tags_d = tags_q + 2'd1;
          open_d = tp_ok && ({30'd0, tags_q + 2'd1} < MAX_TAGS);
        end
      end else if (off_q >= 7'd14) begin
        if ((et_q == ETYPE_V4 && rel >= 7'd12 && rel <= 7'd15) ||
            (et_q == ETYPE_V6 && rel >= 7'd8 && rel <= 7'd23)) begin
          hi_d = {hi_q[55:0], lo_q[63:56]};
          lo_d = {lo_q[55:0], data_i};
        end
      end
      if (off_q != 7'd127) off_d = off_q + 7'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      off_q <= '0; et_q <= '0; tags_q <= '0; open_q <= 1'b0;
      hi_q <= '0; lo_q <= '0;
    end else begin
      off_q <= off_d; et_q <= et_d; tags_q <= tags_d; open_q <= open_d;
      hi_q <= hi_d; lo_q <= lo_d;
    end
  end

  assign len = off_q;
  assign stat_o.long_enough = len >= 7'd14;
  assign stat_o.tag_open    = open_q;
  assign stat_o.tags        = tags_q;
  assign stat_o.is_v4       = et_q == ETYPE_V4;
  assign stat_o.is_v6       = et_q == ETYPE_V6;
  assign stat_o.v4_full     = {1'b0, len} >= {1'b0, base} + 8'd20;
  assign stat_o.v6_full     = {1'b0, len} >= {1'b0, base} + 8'd40;
  assign src_hi_o = hi_q;
  assign src_lo_o = lo_q;
endmodule

// ----- hdl/vipsf_counters.sv -----
// Seven 64-bit wrapping event counters with one shared incrementer,
// bumped one counter per cycle. Depends on vipsf_pkg.
`timescale 1ns / 1ps
module vipsf_counters
  import vipsf_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        inc_i,
  input  logic [2:0]  inc_sel_i,
  input  logic [2:0]  rd_sel_i,
  output logic [63:0] rd_val_o
);
  logic [63:0] cnt_q [CNT_NUM];
  logic [63:0] sum;

  assign sum = cnt_q[inc_sel_i[2:0] == 3'd7 ? 3'd0 : inc_sel_i] + 64'd1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CNT_NUM; i++) cnt_q[i] <= '0;
    end else if (inc_i && inc_sel_i != 3'd7) begin
      cnt_q[inc_sel_i] <= sum;
    end
  end

  assign rd_val_o = (rd_sel_i == 3'd7) ? 64'd0 : cnt_q[rd_sel_i];
endmodule

// ----- hdl/vlan_ip_source_filter.sv -----
// Top level of the VLAN IP source filter: handshake, sequencer, table RAMs
// and the shared compare unit. Depends on vipsf_pkg, vipsf_ram, vipsf_parser,
// vipsf_counters.
//
//  channel | valid    | stall    | payload
//  in      | valid_i  | stall_o  | cmd_i .. counter_select_i
//  out     | valid_o  | stall_i  | result_kind_o .. counter_value_o
//
// The input stalls while the sequencer is busy with a counter read or a packet.
// After the last byte a classify state follows; for a complete IPv4 or IPv6
// header the sequencer then walks one table entry per cycle through the shared
// compare unit, up to ALLOW+DENY depth of the packet's family, stopping at the
// first hit. Up to 4 counter updates follow, one per cycle, then the result loads.
// Tables need no clearing pass: active bits live in flip-flops cleared by reset.
// The input stalls while a result waits on a stalled output.
`timescale 1ns / 1ps
module vlan_ip_source_filter
  import vipsf_pkg::*;
#(
  parameter int ALLOW4_DEPTH = ALLOW4_DEPTH_DEF,
  parameter int ALLOW6_DEPTH = ALLOW6_DEPTH_DEF,
  parameter int DENY4_DEPTH  = DENY4_DEPTH_DEF,
  parameter int DENY6_DEPTH  = DENY6_DEPTH_DEF,
  parameter int MAX_TAGS     = MAX_TAGS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        stall_o,
  input  logic [2:0]  cmd_i,
  input  logic [7:0]  data_byte_i,
  input  logic        last_byte_i,
  input  logic [5:0]  entry_index_i,
  input  logic [63:0] entry_addr_high_i,
  input  logic [63:0] entry_addr_low_i,
  input  logic [7:0]  entry_prefix_len_i,
  input  logic        entry_valid_i,
  input  logic [2:0]  counter_select_i,
  output logic        valid_o,
  input  logic        stall_i,
  output logic        result_kind_o,
  output logic        verdict_o,
  output logic [2:0]  verdict_reason_o,
  output logic        vlan_present_o,
  output logic        was_ipv6_o,
  output logic [63:0] counter_value_o
);
  localparam int A4W = (ALLOW4_DEPTH > 1) ? $clog2(ALLOW4_DEPTH) : 1;
  localparam int A6W = (ALLOW6_DEPTH > 1) ? $clog2(ALLOW6_DEPTH) : 1;
  localparam int D4W = (DENY4_DEPTH > 1) ? $clog2(DENY4_DEPTH) : 1;
  localparam int D6W = (DENY6_DEPTH > 1) ? $clog2(DENY6_DEPTH) : 1;
  localparam int IW  = 17;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_WALK  = 3'd1;
  localparam logic [2:0] S_CNT   = 3'd2;
  localparam logic [2:0] S_OUT   = 3'd3;
  localparam logic [2:0] S_CRD   = 3'd4;

  logic [2:0] st_q, st_d;
  logic       acc;
  assign acc     = valid_i && !stall_o;
  assign stall_o = (st_q != S_IDLE) || (valid_o && stall_i);

  // table writes
  logic       in_a4, in_a6, in_d4, in_d6;
  assign in_a4 = {26'd0, entry_index_i} < ALLOW4_DEPTH;
  assign in_a6 = {26'd0, entry_index_i} < ALLOW6_DEPTH;
  assign in_d4 = {26'd0, entry_index_i} < DENY4_DEPTH;
  assign in_d6 = {26'd0, entry_index_i} < DENY6_DEPTH;
  logic we_a4, we_a6, we_d4, we_d6;
  assign we_a4 = acc && cmd_i == CMD_ALLOW4 && in_a4;
  assign we_a6 = acc && cmd_i == CMD_ALLOW6 && in_a6;
  assign we_d4 = acc && cmd_i == CMD_DENY4 && in_d4;
  assign we_d6 = acc && cmd_i == CMD_DENY6 && in_d6;

  logic [ALLOW4_DEPTH-1:0] a4_act_q;
  logic [ALLOW6_DEPTH-1:0] a6_act_q;
  logic [DENY4_DEPTH-1:0]  d4_act_q;
  logic [DENY6_DEPTH-1:0]  d6_act_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a4_act_q <= '0; a6_act_q <= '0; d4_act_q <= '0; d6_act_q <= '0;
    end else begin
      if (we_a4) a4_act_q[entry_index_i[A4W-1:0]] <= entry_valid_i;
      if (we_a6) a6_act_q[entry_index_i[A6W-1:0]] <= entry_valid_i;
      if (we_d4) d4_act_q[entry_index_i[D4W-1:0]] <= entry_valid_i;
      if (we_d6) d6_act_q[entry_index_i[D6W-1:0]] <= entry_valid_i;
    end
  end

  logic [5:0] plen4;
  logic [7:0] plen6;
  assign plen4 = (entry_prefix_len_i > 8'd32) ? 6'd32 : entry_prefix_len_i[5:0];
  assign plen6 = (entry_prefix_len_i > 8'd128) ? 8'd128 : entry_prefix_len_i;

  // walk index, address register into RAMs
  logic [IW-1:0] idx_q, idx_d;
  logic [IW-1:0] ridx_q;
  logic          rvalid_q;
  logic          phase_q, phase_d;   // 0 allow, 1 deny
  logic          rphase_q;

  logic [37:0]  a4_rd;
  logic [135:0] a6_rd;
  logic [31:0]  d4_rd;
  logic [127:0] d6_rd;

  vipsf_ram #(.WIDTH(38), .DEPTH(ALLOW4_DEPTH)) u_a4 (
    .clk_i, .we_i(we_a4), .waddr_i(entry_index_i[A4W-1:0]),
    .wdata_i({plen4, entry_addr_low_i[31:0]}),
    .raddr_i(idx_q[A4W-1:0]), .rdata_o(a4_rd));
  vipsf_ram #(.WIDTH(136), .DEPTH(ALLOW6_DEPTH)) u_a6 (
    .clk_i, .we_i(we_a6), .waddr_i(entry_index_i[A6W-1:0]),
    .wdata_i({plen6, entry_addr_high_i, entry_addr_low_i}),
    .raddr_i(idx_q[A6W-1:0]), .rdata_o(a6_rd));
  vipsf_ram #(.WIDTH(32), .DEPTH(DENY4_DEPTH)) u_d4 (
    .clk_i, .we_i(we_d4), .waddr_i(entry_index_i[D4W-1:0]),
    .wdata_i(entry_addr_low_i[31:0]),
    .raddr_i(idx_q[D4W-1:0]), .rdata_o(d4_rd));
  vipsf_ram #(.WIDTH(128), .DEPTH(DENY6_DEPTH)) u_d6 (
    .clk_i, .we_i(we_d6), .waddr_i(entry_index_i[D6W-1:0]),
    .wdata_i({entry_addr_high_i, entry_addr_low_i}),
    .raddr_i(idx_q[D6W-1:0]), .rdata_o(d6_rd));

  // parser
  pkt_stat_t   stat;
  logic [63:0] src_hi, src_lo;
  logic        pclear;
  vipsf_parser #(.MAX_TAGS(MAX_TAGS)) u_parser (
    .clk_i, .rst_ni, .byte_i(acc && cmd_i == CMD_BYTE), .clear_i(pclear),
    .data_i(data_byte_i), .stat_o(stat), .src_hi_o(src_hi), .src_lo_o(src_lo));

  // packet context latched at last byte
  logic v6_q, v6_d;
  logic [2:0] rsn_q, rsn_d;
  logic drop_q, drop_d;
  logic [3:0] cnt_pend_q, cnt_pend_d;   // bits: total, vlan, v6seen, nonip
  logic found_q, found_d;

  // shared compare unit on registered RAM data
  logic [63:0] mh, ml, cmp_hi, cmp_lo, m4;
  logic        hit;
  logic        act;
  always_comb begin
    mh = '1; ml = '1; cmp_hi = '0; cmp_lo = '0; act = 1'b0;
    m4 = mask_hi({2'b00, a4_rd[37:32]});
    if (!v6_q) begin
      cmp_hi = '0;
      if (!rphase_q) begin
        mh = '0;
        ml = {32'd0, m4[63:32]};
        cmp_lo = {32'd0, a4_rd[31:0]};
        act = a4_act_q[ridx_q[A4W-1:0]] && ({15'd0, ridx_q} < ALLOW4_DEPTH);
      end else begin
        mh = '0; ml = 64'h0000_0000_FFFF_FFFF;
        cmp_lo = {32'd0, d4_rd};
        act = d4_act_q[ridx_q[D4W-1:0]] && ({15'd0, ridx_q} < DENY4_DEPTH);
      end
    end else begin
      if (!rphase_q) begin
        mh = mask_hi(a6_rd[135:128]); ml = mask_lo(a6_rd[135:128]);
        cmp_hi = a6_rd[127:64]; cmp_lo = a6_rd[63:0];
        act = a6_act_q[ridx_q[A6W-1:0]] && ({15'd0, ridx_q} < ALLOW6_DEPTH);
      end else begin
        cmp_hi = d6_rd[127:64]; cmp_lo = d6_rd[63:0];
        act = d6_act_q[ridx_q[D6W-1:0]] && ({15'd0, ridx_q} < DENY6_DEPTH);
      end
    end
    hit = act && rvalid_q && (((src_hi ^ cmp_hi) & mh) == '0) &&
          ((((v6_q ? src_lo : {32'd0, src_lo[31:0]}) ^ cmp_lo) & ml) == '0);
  end

  logic [IW-1:0] depth_cur;
  always_comb begin
    case ({v6_q, phase_q})
      2'b00:   depth_cur = IW'(ALLOW4_DEPTH);
      2'b01:   depth_cur = IW'(DENY4_DEPTH);
      2'b10:   depth_cur = IW'(ALLOW6_DEPTH);
      default: depth_cur = IW'(DENY6_DEPTH);
    endcase
  end

  // counters
  logic       cinc;
  logic [2:0] csel;
  logic [63:0] cval;
  logic [2:0] rd_sel_q;
  vipsf_counters u_cnt (.clk_i, .rst_ni, .inc_i(cinc), .inc_sel_i(csel),
    .rd_sel_i(rd_sel_q), .rd_val_o(cval));

  // output register
  logic        ov_q, ok_q, overd_q, ovlan_q, ov6_q;
  logic [2:0]  orsn_q;
  logic [63:0] oval_q;
  logic        load_v, load_c;
  logic        vlan_q, vlan_d;

  always_comb begin
    st_d = st_q; idx_d = idx_q; phase_d = phase_q;
    v6_d = v6_q; rsn_d = rsn_q; drop_d = drop_q; cnt_pend_d = cnt_pend_q;
    found_d = found_q; vlan_d = vlan_q;
    pclear = 1'b0; cinc = 1'b0; csel = 3'd7; load_v = 1'b0; load_c = 1'b0;
    case (st_q)
      S_IDLE: begin
        if (acc && cmd_i == CMD_CREAD) st_d = S_CRD;
        else if (acc && cmd_i == CMD_BYTE && last_byte_i) begin
          // statuses reflect this byte only next cycle; decide then
          st_d = S_OUT; rsn_d = RSN_TRUNC; drop_d = 1'b0;
          found_d = 1'b0;
        end
      end
      S_OUT: begin
        // first cycle after last byte: classify
        v6_d = stat.is_v6; vlan_d = 1'b0; cnt_pend_d = '0;
        idx_d = '0; phase_d = 1'b0; st_d = S_CNT;
        if (stat.long_enough) begin
          cnt_pend_d[0] = 1'b1;
          if (stat.tags != 2'd0) begin vlan_d = 1'b1; cnt_pend_d[1] = 1'b1; end
          if (stat.tag_open) rsn_d = RSN_TRUNC;
          else if (stat.is_v4) begin
            if (stat.v4_full) begin st_d = S_WALK; rsn_d = RSN_DEFAULT; end
          end else if (stat.is_v6) begin
            if (stat.v6_full) begin
              st_d = S_WALK; rsn_d = RSN_DEFAULT; cnt_pend_d[2] = 1'b1;
            end
          end else begin
            rsn_d = RSN_NONIP; cnt_pend_d[3] = 1'b1;
          end
        end
      end
      S_WALK: begin
        if (hit && !found_q) begin
          found_d = 1'b1;
          if (!rphase_q) begin rsn_d = RSN_ALLOW; drop_d = 1'b0; end
          else begin
            rsn_d = v6_q ? RSN_DENY6 : RSN_DENY4; drop_d = 1'b1;
          end
          st_d = S_CNT;
        end else if (idx_q == depth_cur) begin
          if (!rvalid_q) begin
            // pipeline drained for this phase
            if (!phase_q) begin phase_d = 1'b1; idx_d = '0; end
            else st_d = S_CNT;
          end
        end else idx_d = idx_q + 1'b1;
      end
      S_CNT: begin
        if (cnt_pend_q[0]) begin
          cinc = 1'b1; csel = 3'(CNT_TOTAL); cnt_pend_d[0] = 1'b0;
        end else if (cnt_pend_q[1]) begin
          cinc = 1'b1; csel = 3'(CNT_VLAN); cnt_pend_d[1] = 1'b0;
        end else if (cnt_pend_q[2]) begin
          cinc = 1'b1; csel = 3'(CNT_V6SEEN); cnt_pend_d[2] = 1'b0;
        end else if (cnt_pend_q[3]) begin
          cinc = 1'b1; csel = 3'(CNT_NONIP); cnt_pend_d[3] = 1'b0;
        end else if (found_q) begin
          cinc = 1'b1; found_d = 1'b0;
          case (rsn_q)
            RSN_ALLOW: csel = 3'(CNT_ALLOW);
            RSN_DENY4: csel = 3'(CNT_DENY4);
            RSN_DENY6: csel = 3'(CNT_DENY6);
            default:   csel = 3'd7;
          endcase
        end else begin
          load_v = 1'b1; pclear = 1'b1; st_d = S_IDLE;
        end
      end
      S_CRD: begin
        load_c = 1'b1; st_d = S_IDLE;
      end
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE; idx_q <= '0; ridx_q <= '0; rvalid_q <= 1'b0;
      phase_q <= 1'b0; rphase_q <= 1'b0; v6_q <= 1'b0; rsn_q <= RSN_TRUNC;
      drop_q <= 1'b0; cnt_pend_q <= '0; found_q <= 1'b0; vlan_q <= 1'b0;
      rd_sel_q <= '0; ov_q <= 1'b0;
    end else begin
      st_q <= st_d; idx_q <= idx_d; phase_q <= phase_d;
      ridx_q <= idx_q; rphase_q <= phase_q;
      rvalid_q <= (st_q == S_WALK) && (idx_q != depth_cur) && !(hit && !found_q)
                  && (st_d == S_WALK);
      v6_q <= v6_d; rsn_q <= rsn_d; drop_q <= drop_d; cnt_pend_q <= cnt_pend_d;
      found_q <= found_d; vlan_q <= vlan_d;
      if (acc && cmd_i == CMD_CREAD) rd_sel_q <= counter_select_i;
      if (load_v || load_c) ov_q <= 1'b1;
      else if (!stall_i) ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_v) begin
      ok_q <= 1'b0; overd_q <= drop_q; orsn_q <= rsn_q; ovlan_q <= vlan_q;
      ov6_q <= v6_q; oval_q <= '0;
    end else if (load_c) begin
      ok_q <= 1'b1; overd_q <= 1'b0; orsn_q <= RSN_TRUNC; ovlan_q <= 1'b0;
      ov6_q <= 1'b0; oval_q <= cval;
    end
  end

  assign valid_o          = ov_q;
  assign result_kind_o    = ok_q;
  assign verdict_o        = overd_q;
  assign verdict_reason_o = orsn_q;
  assign vlan_present_o   = ovlan_q;
  assign was_ipv6_o       = ov6_q;
  assign counter_value_o  = oval_q;
endmodule

// ----- hdl/vipsf_checker.sv -----
// Port-level checker for the VLAN IP source filter, bound to the top level.
// Depends on vipsf_pkg and vlan_ip_source_filter.
`timescale 1ns / 1ps
module vipsf_checker
  import vipsf_pkg::*;
(
  input logic       clk_i,
  input logic       rst_ni,
  input logic       stall_o,
  input logic       valid_o,
  input logic       stall_i,
  input logic       result_kind_o,
  input logic       verdict_o,
  input logic [2:0] verdict_reason_o,
  input logic [63:0] counter_value_o
);
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && stall_i |=> valid_o) else $error("result dropped while stalled");
  a_drop_rsn: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !result_kind_o && verdict_o |->
      (verdict_reason_o == RSN_DENY4 || verdict_reason_o == RSN_DENY6))
    else $error("drop without deny reason");
  a_cnt_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !result_kind_o |-> counter_value_o == 64'd0)
    else $error("verdict carries counter data");
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && stall_i |-> stall_o) else $error("input taken with result pending");
endmodule

bind vlan_ip_source_filter vipsf_checker u_vipsf_checker (
  .clk_i, .rst_ni, .stall_o, .valid_o, .stall_i, .result_kind_o,
  .verdict_o, .verdict_reason_o, .counter_value_o);

// ----- tb/sv/tb_top.sv -----
// Testbench for vlan_ip_source_filter: random packets, table writes and counter
// reads, checked against a scoreboard that predicts every verdict and readout.
// Depends on vipsf_pkg and the filter RTL.
`timescale 1ns / 1ps
module tb_top;
  import vipsf_pkg::*;

  typedef struct {
    logic [2:0]  cmd;
    logic [7:0]  data;
    logic        last;
    logic [5:0]  index;
    logic [63:0] addr_hi;
    logic [63:0] addr_lo;
    logic [7:0]  plen;
    logic        active;
    logic [2:0]  sel;
    bit          drain_first;
  } item_t;

  typedef struct {
    logic        kind;
    logic        drop;
    logic [2:0]  reason;
    logic        vlan;
    logic        v6;
    logic [63:0] value;
  } outcome_t;

  class filter_scoreboard;
    int           offset;
    logic [15:0]  etype;
    int           tags;
    logic [127:0] src;
    bit           tag_open;
    logic [31:0]  a4_addr [64];
    int           a4_len [64];
    bit           a4_on [64];
    logic [127:0] a6_addr [32];
    int           a6_len [32];
    bit           a6_on [32];
    logic [31:0]  d4_addr [64];
    bit           d4_on [64];
    logic [127:0] d6_addr [32];
    bit           d6_on [32];
    logic [63:0]  events [CNT_NUM];
    outcome_t     pending_q[$];
    int           errors;

    function void clear_packet();
      offset = 0; etype = '0; tags = 0; src = '0; tag_open = 0;
    endfunction

    function bit tpid_match(logic [15:0] t);
      return (t == TPID_C || t == TPID_S) && tags < MAX_TAGS_DEF;
    endfunction

    function void parse_byte(logic [7:0] b);
      int rel;
      rel = offset - (14 + 4 * tags);
      if (offset == 12 || offset == 13) begin
        etype = {etype[7:0], b};
        if (offset == 13) tag_open = tpid_match(etype);
      end else if (offset >= 14 && tag_open) begin
        if (rel == 2 || rel == 3) etype = {etype[7:0], b};
        if (rel == 3) begin
          tags = (tags + 1) & 3;
          tag_open = tpid_match(etype);
        end
      end else if (offset >= 14) begin
        if ((etype == ETYPE_V4 && rel >= 12 && rel <= 15) ||
            (etype == ETYPE_V6 && rel >= 8 && rel <= 23))
          src = {src[119:0], b};
      end
      if (offset < 127) offset++;
    endfunction

    function bit allow4_hit(logic [31:0] a);
      logic [31:0] m;
      foreach (a4_on[i]) if (a4_on[i]) begin
        m = (a4_len[i] == 0) ? 32'h0 : (32'hFFFF_FFFF << (32 - a4_len[i]));
        if (((a ^ a4_addr[i]) & m) == 0) return 1;
      end
      return 0;
    endfunction

    function bit allow6_hit(logic [127:0] a);
      logic [127:0] m;
      foreach (a6_on[i]) if (a6_on[i]) begin
        m = (a6_len[i] == 0) ? '0 : ({128{1'b1}} << (128 - a6_len[i]));
        if (((a ^ a6_addr[i]) & m) == 0) return 1;
      end
      return 0;
    endfunction

    function bit d4_hit(logic [31:0] a);
      foreach (d4_on[i]) if (d4_on[i] && d4_addr[i] == a) return 1;
      return 0;
    endfunction

    function bit d6_hit(logic [127:0] a);
      foreach (d6_on[i]) if (d6_on[i] && d6_addr[i] == a) return 1;
      return 0;
    endfunction

    function outcome_t close_packet();
      outcome_t r;
      int base;
      r = '{default: '0};
      base = 14 + 4 * tags;
      r.reason = RSN_TRUNC;
      if (offset >= 14) begin
        events[CNT_TOTAL]++;
        if (tags > 0) begin
          r.vlan = 1;
          events[CNT_VLAN]++;
        end
        if (tag_open) begin
          r.reason = RSN_TRUNC;
        end else if (etype == ETYPE_V4) begin
          if (offset < base + 20) r.reason = RSN_TRUNC;
          else if (allow4_hit(src[31:0])) begin
            r.reason = RSN_ALLOW; events[CNT_ALLOW]++;
          end else if (d4_hit(src[31:0])) begin
            r.drop = 1; r.reason = RSN_DENY4; events[CNT_DENY4]++;
          end else r.reason = RSN_DEFAULT;
        end else if (etype == ETYPE_V6) begin
          r.v6 = 1;
          if (offset < base + 40) r.reason = RSN_TRUNC;
          else begin
            events[CNT_V6SEEN]++;
            if (allow6_hit(src)) begin
              r.reason = RSN_ALLOW; events[CNT_ALLOW]++;
            end else if (d6_hit(src)) begin
              r.drop = 1; r.reason = RSN_DENY6; events[CNT_DENY6]++;
            end else r.reason = RSN_DEFAULT;
          end
        end else begin
          r.reason = RSN_NONIP;
          events[CNT_NONIP]++;
        end
      end
      clear_packet();
      return r;
    endfunction

    function void reset_state();
      clear_packet();
      foreach (a4_on[i]) begin a4_on[i] = 0; d4_on[i] = 0; end
      foreach (a6_on[i]) begin a6_on[i] = 0; d6_on[i] = 0; end
      foreach (events[i]) events[i] = '0;
      errors = 0;
    endfunction

    function void note_input(item_t it);
      outcome_t r;
      case (it.cmd)
        CMD_BYTE: begin
          parse_byte(it.data);
          if (it.last) pending_q.push_back(close_packet());
        end
        CMD_ALLOW4: begin
          a4_addr[it.index] = it.addr_lo[31:0];
          a4_len[it.index] = (it.plen > 32) ? 32 : it.plen;
          a4_on[it.index] = it.active;
        end
        CMD_ALLOW6: if (it.index < 32) begin
          a6_addr[it.index] = {it.addr_hi, it.addr_lo};
          a6_len[it.index] = (it.plen > 128) ? 128 : it.plen;
          a6_on[it.index] = it.active;
        end
        CMD_DENY4: begin
          d4_addr[it.index] = it.addr_lo[31:0];
          d4_on[it.index] = it.active;
        end
        CMD_DENY6: if (it.index < 32) begin
          d6_addr[it.index] = {it.addr_hi, it.addr_lo};
          d6_on[it.index] = it.active;
        end
        CMD_CREAD: begin
          r = '{default: '0};
          r.kind = 1;
          r.value = (it.sel < CNT_NUM) ? events[it.sel] : '0;
          pending_q.push_back(r);
        end
        default: ;
      endcase
    endfunction

    function void check_result(outcome_t got);
      outcome_t w;
      if (pending_q.size() == 0) begin
        $error("result with nothing expected: kind %0d", got.kind);
        errors++;
        return;
      end
      w = pending_q.pop_front();
      if (got.kind !== w.kind) begin
        $error("result_kind exp %0d got %0d", w.kind, got.kind); errors++;
      end
      if (got.drop !== w.drop) begin
        $error("verdict exp %0d got %0d", w.drop, got.drop); errors++;
      end
      if (got.reason !== w.reason) begin
        $error("verdict_reason exp %0d got %0d", w.reason, got.reason); errors++;
      end
      if (got.vlan !== w.vlan) begin
        $error("vlan_present exp %0d got %0d", w.vlan, got.vlan); errors++;
      end
      if (got.v6 !== w.v6) begin
        $error("was_ipv6 exp %0d got %0d", w.v6, got.v6); errors++;
      end
      if (got.value !== w.value) begin
        $error("counter_value exp %0h got %0h", w.value, got.value); errors++;
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        valid_i = 1'b0;
  logic        stall_o;
  logic [2:0]  cmd_i = '0;
  logic [7:0]  data_byte_i = '0;
  logic        last_byte_i = 1'b0;
  logic [5:0]  entry_index_i = '0;
  logic [63:0] entry_addr_high_i = '0;
  logic [63:0] entry_addr_low_i = '0;
  logic [7:0]  entry_prefix_len_i = '0;
  logic        entry_valid_i = 1'b0;
  logic [2:0]  counter_select_i = '0;
  logic        valid_o;
  logic        stall_i = 1'b0;
  logic        result_kind_o;
  logic        verdict_o;
  logic [2:0]  verdict_reason_o;
  logic        vlan_present_o;
  logic        was_ipv6_o;
  logic [63:0] counter_value_o;

  vlan_ip_source_filter dut (.*);

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  filter_scoreboard sb = new();
  item_t        stim_q[$];
  logic [31:0]  pool4 [16];
  logic [127:0] pool6 [16];
  int           result_cnt;
  bit           quiet;
  bit           hold_off_go;

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic item_t blank_item();
    item_t it;
    it = '{default: '0};
    it.index = 6'($urandom_range(0, 63));
    it.addr_hi = rand64();
    it.addr_lo = rand64();
    it.plen = 8'($urandom_range(0, 255));
    it.active = 1'($urandom_range(0, 1));
    it.sel = 3'($urandom_range(0, 7));
    return it;
  endfunction

  task automatic add_byte(logic [7:0] b, logic last);
    item_t it;
    it = blank_item();
    it.cmd = CMD_BYTE;
    it.data = b;
    it.last = last;
    stim_q.push_back(it);
    if (last) result_cnt++;
  endtask

  task automatic add_cmd(logic [2:0] c, int idx, logic [127:0] a, int plen, bit on, int sel);
    item_t it;
    it = blank_item();
    it.cmd = c;
    it.data = 8'($urandom_range(0, 255));
    it.last = 1'($urandom_range(0, 1));
    if (idx >= 0) it.index = 6'(idx);
    {it.addr_hi, it.addr_lo} = a;
    if (plen >= 0) it.plen = 8'(plen);
    it.active = on;
    if (sel >= 0) it.sel = 3'(sel);
    stim_q.push_back(it);
    if (c == CMD_CREAD) result_cnt++;
  endtask

  task automatic random_cmd();
    int c;
    int p;
    logic [127:0] a;
    c = $urandom_range(1, 7);
    a = {rand64(), rand64()};
    case (c)
      CMD_ALLOW4, CMD_DENY4: begin
        a[31:0] = pool4[$urandom_range(0, 15)];
        p = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : $urandom_range(8, 32);
      end
      CMD_ALLOW6, CMD_DENY6: begin
        a = pool6[$urandom_range(0, 15)];
        p = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : $urandom_range(32, 128);
      end
      default: p = -1;
    endcase
    add_cmd(c[2:0], -1, a, p, $urandom_range(0, 3) != 0, -1);
  endtask

  // ntags > 2 leaves a third tag in place, so the packet reads as non-IP.
  task automatic add_packet(int ntags, logic [15:0] et, logic [127:0] src, int cut,
                            int extra, bit noisy);
    logic [7:0] pkt[$];
    logic [15:0] t;
    int hlen;
    int n;
    repeat (12) pkt.push_back(8'($urandom_range(0, 255)));
    repeat (ntags) begin
      t = $urandom_range(0, 1) ? TPID_C : TPID_S;
      pkt.push_back(t[15:8]); pkt.push_back(t[7:0]);
      pkt.push_back(8'($urandom_range(0, 255))); pkt.push_back(8'($urandom_range(0, 255)));
    end
    pkt.push_back(et[15:8]); pkt.push_back(et[7:0]);
    hlen = (et == ETYPE_V6) ? 40 : 20;
    for (int i = 0; i < hlen; i++) begin
      if (et == ETYPE_V4 && i >= 12 && i < 16) pkt.push_back(src[8 * (15 - i) +: 8]);
      else if (et == ETYPE_V6 && i >= 8 && i < 24) pkt.push_back(src[8 * (23 - i) +: 8]);
      else pkt.push_back(8'($urandom_range(0, 255)));
    end
    repeat (extra) pkt.push_back(8'($urandom_range(0, 255)));
    n = (cut > 0 && cut < pkt.size()) ? cut : pkt.size();
    for (int i = 0; i < n; i++) begin
      if (noisy && $urandom_range(0, 24) == 0) random_cmd();
      add_byte(pkt[i], i == n - 1);
    end
  endtask

  task automatic random_packet();
    int r;
    int ntags;
    logic [15:0] et;
    logic [127:0] s;
    int cut;
    int extra;
    r = $urandom_range(0, 9);
    ntags = (r < 5) ? 0 : (r < 7) ? 1 : (r < 9) ? 2 : 3;
    r = $urandom_range(0, 9);
    et = (r < 4) ? ETYPE_V4 : (r < 8) ? ETYPE_V6 : 16'($urandom_range(0, 16'hFFFF));
    s = (et == ETYPE_V6) ? pool6[$urandom_range(0, 15)]
                         : {96'h0, pool4[$urandom_range(0, 15)]};
    if ($urandom_range(0, 3) == 0) s[$urandom_range(0, (et == ETYPE_V6) ? 127 : 31)] ^= 1'b1;
    if ($urandom_range(0, 4) == 0) s = {rand64(), rand64()};
    cut = ($urandom_range(0, 6) == 0) ? $urandom_range(1, 60) : 0;
    extra = ($urandom_range(0, 19) == 0) ? $urandom_range(60, 100) : $urandom_range(0, 4);
    add_packet(ntags, et, s, cut, extra, 1);
  endtask

  task automatic build_stimulus();
    foreach (pool4[i]) pool4[i] = $urandom();
    foreach (pool6[i]) pool6[i] = {rand64(), rand64()};
    pool4[0] = '0; pool4[1] = '1;
    pool6[0] = '0; pool6[1] = '1;
    // directed: edge slots, long prefixes, ignored commands, odd selectors
    add_cmd(CMD_ALLOW4, 0, {96'h0, pool4[2]}, 24, 1, -1);
    add_cmd(CMD_ALLOW4, 63, {96'h0, pool4[1]}, 255, 1, -1);
    add_cmd(CMD_DENY4, 63, {96'h0, pool4[3]}, -1, 1, -1);
    add_cmd(CMD_DENY4, 0, {96'h0, pool4[0]}, -1, 1, -1);
    add_cmd(CMD_ALLOW6, 31, pool6[2], 200, 1, -1);
    add_cmd(CMD_ALLOW6, 40, pool6[3], 0, 1, -1);
    add_cmd(CMD_DENY6, 31, pool6[3], -1, 1, -1);
    add_cmd(CMD_DENY6, 63, pool6[4], -1, 1, -1);
    add_cmd(3'd6, -1, '1, -1, 1, -1);
    add_cmd(3'd7, -1, '0, -1, 0, -1);
    add_cmd(CMD_CREAD, -1, '0, -1, 0, 7);
    add_packet(0, ETYPE_V4, {96'h0, pool4[2]}, 5, 0, 0);
    add_packet(2, ETYPE_V4, {96'h0, pool4[2]}, 17, 0, 0);
    add_packet(0, ETYPE_V4, {96'h0, pool4[2] ^ 32'h1}, 0, 0, 0);
    add_packet(1, ETYPE_V4, {96'h0, pool4[3]}, 0, 0, 0);
    add_packet(0, ETYPE_V4, {96'h0, pool4[3]}, 30, 0, 0);
    add_packet(2, ETYPE_V6, pool6[2], 0, 0, 0);
    add_packet(0, ETYPE_V6, pool6[3], 0, 0, 0);
    add_packet(0, ETYPE_V6, pool6[3], 50, 0, 0);
    add_packet(3, ETYPE_V4, '0, 0, 0, 0);
    add_packet(0, 16'h0806, '0, 0, 100, 0);
    for (int s = 0; s <= 7; s++) add_cmd(CMD_CREAD, -1, '0, -1, 0, s);
    stim_q[stim_q.size() - 1].drain_first = 1;
    while (stim_q.size() < 1550 || result_cnt < 60) begin
      if ($urandom_range(0, 2) == 0) random_cmd();
      else random_packet();
    end
    for (int s = 0; s < CNT_NUM; s++) add_cmd(CMD_CREAD, -1, '0, -1, 0, s);
    stim_q[stim_q.size() / 2].drain_first = 1;
  endtask

  task automatic send_all();
    item_t it;
    int total;
    total = stim_q.size();
    for (int k = 0; k < total; k++) begin
      it = stim_q[k];
      if (k == total / 4) hold_off_go = 1;
      if (k > total * 9 / 10) quiet = 1;
      if (it.drain_first) begin
        valid_i <= 1'b0;
        while (sb.pending_q.size() > 0) @(posedge clk_i);
        repeat (200) @(posedge clk_i);
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        valid_i <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk_i);
      end
      valid_i <= 1'b1;
      cmd_i <= it.cmd;
      data_byte_i <= it.data;
      last_byte_i <= it.last;
      entry_index_i <= it.index;
      entry_addr_high_i <= it.addr_hi;
      entry_addr_low_i <= it.addr_lo;
      entry_prefix_len_i <= it.plen;
      entry_valid_i <= it.active;
      counter_select_i <= it.sel;
      do @(posedge clk_i); while (stall_o);
      sb.note_input(it);
    end
    valid_i <= 1'b0;
  endtask

  initial begin
    sb.reset_state();
    build_stimulus();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    send_all();
    while (sb.pending_q.size() > 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending_q.size() == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

  // receiver back-pressure, with one long hold-off while the sender keeps going
  initial begin
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_off_go) begin
        hold_off_go = 0;
        stall_i <= 1'b1;
        repeat (400) @(posedge clk_i);
        stall_i <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        stall_i <= 1'b1;
        repeat ($urandom_range(1, 7)) @(posedge clk_i);
        stall_i <= 1'b0;
      end else begin
        repeat ($urandom_range(1, 10)) @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && valid_o && !stall_i)
      sb.check_result('{result_kind_o, verdict_o, verdict_reason_o, vlan_present_o,
                        was_ipv6_o, counter_value_o});
  end

  initial begin
    #40_000_000;
    $display("end of test: mismatches");
    $finish;
  end
endmodule

// ----- sim.f -----
hdl/vipsf_pkg.sv
hdl/vipsf_ram.sv
hdl/vipsf_parser.sv
hdl/vipsf_counters.sv
hdl/vlan_ip_source_filter.sv
hdl/vipsf_checker.sv
tb/sv/tb_top.sv
